// ----- src/hbdrv_pkg.sv -----
// Shared constants and types for the H-bridge drive block.
// Used by every module under src/.
package hbdrv_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int DUTY_BITS_DEF = 8;

  localparam int TENTHS_W   = 11;
  localparam int MAG_W      = 10;
  localparam int LOCK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Drive is in tenths of a percent; full scale is 100.0 percent
  localparam logic signed [TENTHS_W-1:0] TENTHS_MAX = 11'sd1000;
  localparam logic signed [TENTHS_W-1:0] TENTHS_MIN = -11'sd1000;
  localparam int DUTY_SCALE = 1000;
  localparam int DUTY_ROUND = 500;

  localparam logic OP_DRIVE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVER_ENABLE = 3'd0,
    REG_SENSE_PRESENT = 3'd1,
    REG_LIMIT_COUNTS  = 3'd2,
    REG_SOFT_LOCK     = 3'd3,
    REG_LOCKOUT_MS    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic              driver_enable;
    logic              sense_present;
    logic              soft_lock;
    logic [LOCK_W-1:0] lockout_ms;
    logic              en_write;  // write to driver_enable this cycle
    logic              en_value;  // value being written
  } cfg_t;

endpackage

// ----- src/hbridge_drive_with_overcurrent_lockout.sv -----
// H-bridge drive with over-current lockout: top level, input and result registers.
// A request goes to the input register, then to the result register (m_tvalid).
// Throughput: one request per cycle unless m_tready stalls; fire frees the input.
// Reset (rst, synchronous): empties both registers, clears configuration,
// the lockout counter and the held PWM and bridge-enable outputs.
module hbridge_drive_with_overcurrent_lockout import hbdrv_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // drive_tenths, sense_left, sense_right
  input  logic [((TENTHS_W + 2*ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // opcode
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // pwm_left, pwm_right, bridge_on, locked_out, overcurrent_event, current_peak
  output logic [((2*DUTY_BITS + 3 + ADC_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OUT_W     = 2*DUTY_BITS + 3 + ADC_BITS;
  localparam int OUT_TDATA = ((OUT_W + 7) / 8) * 8;

  cfg_t                cfg;
  logic [ADC_BITS-1:0] limit_counts;

  logic                       in_full;
  logic                       in_opcode;
  logic signed [TENTHS_W-1:0] in_tenths;
  logic [ADC_BITS-1:0]        in_sense_left;
  logic [ADC_BITS-1:0]        in_sense_right;
  logic                       fire;

  logic [DUTY_BITS-1:0] duty_left;
  logic [DUTY_BITS-1:0] duty_right;
  logic [DUTY_BITS-1:0] pwm_left;
  logic [DUTY_BITS-1:0] pwm_right;
  logic                 bridge_on;
  logic                 locked_out;
  logic                 overcurrent_event;
  logic [ADC_BITS-1:0]  current_peak;

  assign fire     = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode      <= s_tuser;
      in_tenths      <= s_tdata[TENTHS_W-1:0];
      in_sense_left  <= s_tdata[TENTHS_W +: ADC_BITS];
      in_sense_right <= s_tdata[TENTHS_W + ADC_BITS +: ADC_BITS];
    end
  end

  hbdrv_cfg #(
    .ADC_BITS(ADC_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .limit_counts (limit_counts)
  );

  hbdrv_duty #(
    .DUTY_BITS(DUTY_BITS)
  ) u_duty (
    .drive_tenths (in_tenths),
    .duty_left    (duty_left),
    .duty_right   (duty_right)
  );

  hbdrv_ctrl #(
    .ADC_BITS  (ADC_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .limit_counts      (limit_counts),
    .fire              (fire),
    .opcode            (in_opcode),
    .sense_left        (in_sense_left),
    .sense_right       (in_sense_right),
    .duty_left         (duty_left),
    .duty_right        (duty_right),
    .pwm_left          (pwm_left),
    .pwm_right         (pwm_right),
    .bridge_on         (bridge_on),
    .locked_out        (locked_out),
    .overcurrent_event (overcurrent_event),
    .current_peak      (current_peak)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_TDATA'({current_peak, overcurrent_event, locked_out, bridge_on,
                             pwm_right, pwm_left});
    end
  end

endmodule

// ----- src/hbdrv_cfg.sv -----
// Configuration register file for the H-bridge drive block.
// Depends on hbdrv_pkg.
module hbdrv_cfg import hbdrv_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [ADC_BITS-1:0]   limit_counts
);

  logic              driver_enable;
  logic              sense_present;
  logic              soft_lock;
  logic [LOCK_W-1:0] lockout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      driver_enable <= 1'b0;
      sense_present <= 1'b0;
      soft_lock     <= 1'b0;
      lockout_ms    <= '0;
      limit_counts  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVER_ENABLE: driver_enable <= cfg_data[0];
        REG_SENSE_PRESENT: sense_present <= cfg_data[0];
        REG_LIMIT_COUNTS:  limit_counts  <= cfg_data[ADC_BITS-1:0];
        REG_SOFT_LOCK:     soft_lock     <= cfg_data[0];
        REG_LOCKOUT_MS:    lockout_ms    <= cfg_data[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.driver_enable = driver_enable;
    cfg.sense_present = sense_present;
    cfg.soft_lock     = soft_lock;
    cfg.lockout_ms    = lockout_ms;
    cfg.en_write      = cfg_we && (cfg_index == REG_DRIVER_ENABLE);
    cfg.en_value      = cfg_data[0];
  end

endmodule

// ----- src/hbdrv_duty.sv -----
// Drive-to-duty scaling: clamp, magnitude, and rounded scale by (2^DUTY_BITS-1)/1000.
// Depends on hbdrv_pkg.
module hbdrv_duty import hbdrv_pkg::*; #(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic signed [TENTHS_W-1:0] drive_tenths,
  output logic [DUTY_BITS-1:0]       duty_left,
  output logic [DUTY_BITS-1:0]       duty_right
);

  // x = mag*(2^D-1)+500 stays below 2^(D+10); the reciprocal below gives an
  // exact floor(x/1000) for every x of that width.
  localparam int X_W   = DUTY_BITS + MAG_W;
  localparam int R_W   = DUTY_BITS + 11;
  localparam int SHIFT = X_W + MAG_W;
  localparam int P_W   = X_W + R_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(DUTY_SCALE - 1)) / 64'(DUTY_SCALE);
  localparam logic [R_W-1:0] RECIP = RECIP_FULL[R_W-1:0];

  logic signed [TENTHS_W-1:0] clamped;
  logic signed [TENTHS_W-1:0] abs_val;
  logic [MAG_W-1:0]           mag;
  logic [X_W-1:0]             x;
  logic [P_W-1:0]             prod;
  logic [DUTY_BITS-1:0]       duty;

  always_comb begin
    if (drive_tenths > TENTHS_MAX) begin
      clamped = TENTHS_MAX;
    end else if (drive_tenths < TENTHS_MIN) begin
      clamped = TENTHS_MIN;
    end else begin
      clamped = drive_tenths;
    end
    abs_val = clamped[TENTHS_W-1] ? -clamped : clamped;
    mag     = abs_val[MAG_W-1:0];
    x       = (X_W'(mag) << DUTY_BITS) - X_W'(mag) + X_W'(DUTY_ROUND);
    prod    = P_W'(x) * P_W'(RECIP);
    duty    = prod[SHIFT +: DUTY_BITS];
    duty_left  = clamped[TENTHS_W-1] ? '0 : duty;
    duty_right = clamped[TENTHS_W-1] ? duty : '0;
  end

endmodule

// ----- src/hbdrv_ctrl.sv -----
// Lockout counter, held bridge outputs and per-request decision logic.
// Depends on hbdrv_pkg; takes duty values from hbdrv_duty.
module hbdrv_ctrl import hbdrv_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic [ADC_BITS-1:0]  limit_counts,
  input  logic                 fire,
  input  logic                 opcode,
  input  logic [ADC_BITS-1:0]  sense_left,
  input  logic [ADC_BITS-1:0]  sense_right,
  input  logic [DUTY_BITS-1:0] duty_left,
  input  logic [DUTY_BITS-1:0] duty_right,
  output logic [DUTY_BITS-1:0] pwm_left,
  output logic [DUTY_BITS-1:0] pwm_right,
  output logic                 bridge_on,
  output logic                 locked_out,
  output logic                 overcurrent_event,
  output logic [ADC_BITS-1:0]  current_peak
);

  logic [LOCK_W-1:0]    lockout_left;
  logic [DUTY_BITS-1:0] held_pwm_left;
  logic [DUTY_BITS-1:0] held_pwm_right;
  logic                 held_bridge_on;

  logic [LOCK_W-1:0]    lockout_left_next;
  logic [DUTY_BITS-1:0] held_pwm_left_next;
  logic [DUTY_BITS-1:0] held_pwm_right_next;
  logic                 held_bridge_on_next;
  logic [ADC_BITS-1:0]  peak_raw;

  always_comb begin
    peak_raw            = (sense_left > sense_right) ? sense_left : sense_right;
    lockout_left_next   = lockout_left;
    held_pwm_left_next  = held_pwm_left;
    held_pwm_right_next = held_pwm_right;
    held_bridge_on_next = held_bridge_on;
    overcurrent_event   = 1'b0;
    current_peak        = '0;
    if (opcode == OP_TICK) begin
      if (lockout_left != '0) lockout_left_next = lockout_left - 1'b1;
    end else if (cfg.driver_enable) begin
      if (cfg.sense_present) current_peak = peak_raw;
      held_bridge_on_next = 1'b1;
      if (lockout_left != '0) begin
        held_pwm_left_next  = '0;
        held_pwm_right_next = '0;
      end else if (cfg.sense_present && (limit_counts != '0) &&
                   (peak_raw >= limit_counts)) begin
        overcurrent_event = 1'b1;
        if (cfg.soft_lock) lockout_left_next = cfg.lockout_ms;
        held_pwm_left_next  = '0;
        held_pwm_right_next = '0;
      end else begin
        held_pwm_left_next  = duty_left;
        held_pwm_right_next = duty_right;
      end
    end
    pwm_left   = held_pwm_left_next;
    pwm_right  = held_pwm_right_next;
    bridge_on  = held_bridge_on_next;
    locked_out = (lockout_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_left   <= '0;
      held_pwm_left  <= '0;
      held_pwm_right <= '0;
      held_bridge_on <= 1'b0;
    end else if (cfg.en_write) begin
      // start or stop both park the bridge; stop also drops any lockout
      held_pwm_left  <= '0;
      held_pwm_right <= '0;
      held_bridge_on <= 1'b0;
      if (!cfg.en_value) lockout_left <= '0;
    end else if (fire) begin
      lockout_left   <= lockout_left_next;
      held_pwm_left  <= held_pwm_left_next;
      held_pwm_right <= held_pwm_right_next;
      held_bridge_on <= held_bridge_on_next;
    end
  end

endmodule
